// File: rtl/pita_pkg.sv
// ----------------------------------------------------------------------------
// pita_pkg: shared types and constants of the padded integer to ASCII core
// Item record that passes from the classifier to the engine, character codes,
// mode codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package pita_pkg;

    typedef enum logic [2:0] {
        MODE_SDEC = 3'd0,
        MODE_UDEC = 3'd1,
        MODE_HEXL = 3'd2,
        MODE_HEXU = 3'd3,
        MODE_PTR  = 3'd4
    } t_mode;

    localparam logic [5:0] MAX_WIDTH     = 6'd62;
    localparam logic [5:0] PTR_WIDTH     = 6'd8;
    localparam int         DIG_MAX       = 10;
    localparam int         BUF_AW        = $clog2(DIG_MAX);
    localparam int         FIFO_DEPTH    = 2;
    // floor(v / 10) == (v * RECIP10) >> 35 for every 32-bit v
    localparam logic [31:0] RECIP10      = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT  = 35;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic        ptr;
        logic        hex;
        logic        upper;
        logic        neg;
        logic        zp;
        logic [5:0]  width;
        logic [31:0] mag;
    } t_item;

    function automatic logic [7:0] nibble_char(input logic [3:0] x, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (x < 4'd10) begin
            return CH_ZERO + {4'b0, x};
        end
        return base + {4'b0, x} - 8'd10;
    endfunction

endpackage

// File: rtl/pita_front.sv
// ----------------------------------------------------------------------------
// pita_front: input classifier
// Decodes the mode, takes the magnitude, saturates the width and pushes one
// item record into the queue per accepted transaction.
// ----------------------------------------------------------------------------
module pita_front (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_mode,
    input  logic [31:0]       i_value,
    input  logic [5:0]        i_field_width,
    input  logic              i_pad_zero,
    input  logic              i_full,
    output logic              o_push,
    output pita_pkg::t_item   o_item
);

    logic [5:0] w_width;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_width = (i_field_width > pita_pkg::MAX_WIDTH) ? pita_pkg::MAX_WIDTH
                                                           : i_field_width;

    always_comb begin
        o_item       = '0;
        o_item.width = w_width;
        o_item.mag   = i_value;
        o_item.zp    = i_pad_zero;
        case (pita_pkg::t_mode'(i_mode))
            pita_pkg::MODE_SDEC: begin
                o_item.neg = i_value[31];
                if (i_value[31]) begin
                    o_item.mag = 32'd0 - i_value;
                end
            end
            pita_pkg::MODE_HEXL: begin
                o_item.hex = 1'b1;
            end
            pita_pkg::MODE_HEXU: begin
                o_item.hex   = 1'b1;
                o_item.upper = 1'b1;
            end
            pita_pkg::MODE_PTR: begin
                o_item.hex = 1'b1;
                o_item.ptr = 1'b1;
                o_item.zp  = 1'b1;
                if (w_width == 6'd0) begin
                    o_item.width = pita_pkg::PTR_WIDTH;
                end
            end
            default: begin
                // unsigned decimal, also for the unused codes
            end
        endcase
    end

endmodule

// File: rtl/pita_fifo.sv
// ----------------------------------------------------------------------------
// pita_fifo: item queue
// Short show-ahead queue of classified items between classifier and engine.
// ----------------------------------------------------------------------------
module pita_fifo #(
    parameter int DEPTH = pita_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pita_pkg::t_item   i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output pita_pkg::t_item   o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pita_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/pita_back.sv
// ----------------------------------------------------------------------------
// pita_back: conversion and emission engine
// Splits the magnitude into digits (reciprocal multiply for decimal, nibbles
// for hex), then streams prefix, sign, padding and digits into the output
// register, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pita_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  pita_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_ascii_char,
    output logic              o_last
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_MUL       = 10'b00_0000_0010,
        S_DIV       = 10'b00_0000_0100,
        S_HEX       = 10'b00_0000_1000,
        S_PFX0      = 10'b00_0001_0000,
        S_PFX1      = 10'b00_0010_0000,
        S_SGN_LEAD  = 10'b00_0100_0000,
        S_PAD       = 10'b00_1000_0000,
        S_SGN_TRAIL = 10'b01_0000_0000,
        S_DIG       = 10'b10_0000_0000
    } t_state;

    localparam int QW = 64 - pita_pkg::RECIP_SHIFT;

    t_state          r_state, n_state;
    pita_pkg::t_item r_item;
    logic [31:0]     r_val;
    logic [QW-1:0]   r_q;
    logic [3:0]      r_len;
    logic [pita_pkg::BUF_AW-1:0] r_idx;
    logic [5:0]      r_pads;
    logic [7:0]      r_buf [pita_pkg::DIG_MAX];
    logic            r_ovalid;
    logic [7:0]      r_ochar;
    logic            r_olast;

    logic [63:0]     w_prod;
    logic [31:0]     w_q10, w_rem;
    logic [3:0]      w_nlen;
    logic [6:0]      w_eff, w_w7;
    logic [5:0]      w_pads_new;
    logic            w_conv_done, w_stall, w_emit;
    logic [7:0]      w_char;

    function automatic t_state after_pad(input logic neg, input logic zp);
        return (neg && !zp) ? S_SGN_TRAIL : S_DIG;
    endfunction

    function automatic t_state after_lead(input logic neg, input logic zp,
                                          input logic [5:0] pads);
        return (pads != 6'd0) ? S_PAD : after_pad(neg, zp);
    endfunction

    function automatic t_state after_prefix(input logic neg, input logic zp,
                                            input logic [5:0] pads);
        return (neg && zp) ? S_SGN_LEAD : after_lead(neg, zp, pads);
    endfunction

    assign w_prod  = 64'(r_val) * 64'(pita_pkg::RECIP10);
    assign w_q10   = {r_q, 3'b000} + {2'b00, r_q, 1'b0};
    assign w_rem   = r_val - w_q10;
    assign w_nlen  = r_len + 4'd1;
    // sign counts toward the width in both pad styles
    assign w_eff   = {3'b000, w_nlen} + {6'd0, r_item.neg};
    assign w_w7    = {1'b0, r_item.width};
    assign w_pads_new = (w_w7 > w_eff) ? 6'(w_w7 - w_eff) : 6'd0;
    assign w_conv_done = ((r_state == S_DIV) && (r_q == '0))
                      || ((r_state == S_HEX) && (r_val[31:4] == 28'd0));

    assign w_stall = r_ovalid && !i_ready;
    assign w_emit  = !w_stall && (r_state != S_IDLE) && (r_state != S_MUL)
                  && (r_state != S_DIV) && (r_state != S_HEX);
    assign o_pop   = (r_state == S_IDLE) && i_item_valid;

    always_comb begin
        case (r_state)
            S_PFX0:      w_char = pita_pkg::CH_ZERO;
            S_PFX1:      w_char = pita_pkg::CH_X;
            S_SGN_LEAD:  w_char = pita_pkg::CH_MINUS;
            S_SGN_TRAIL: w_char = pita_pkg::CH_MINUS;
            S_PAD:       w_char = r_item.zp ? pita_pkg::CH_ZERO : pita_pkg::CH_SPACE;
            default:     w_char = r_buf[r_idx];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = i_item.hex ? S_HEX : S_MUL;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV, S_HEX: begin
                if (w_conv_done) begin
                    n_state = r_item.ptr ? S_PFX0
                            : after_prefix(r_item.neg, r_item.zp, w_pads_new);
                end else if (r_state == S_DIV) begin
                    n_state = S_MUL;
                end
            end
            S_PFX0: if (w_emit) n_state = S_PFX1;
            S_PFX1: if (w_emit) n_state = after_prefix(r_item.neg, r_item.zp, r_pads);
            S_SGN_LEAD: if (w_emit) n_state = after_lead(r_item.neg, r_item.zp, r_pads);
            S_PAD: begin
                if (w_emit && (r_pads == 6'd1)) begin
                    n_state = after_pad(r_item.neg, r_item.zp);
                end
            end
            S_SGN_TRAIL: if (w_emit) n_state = S_DIG;
            S_DIG: begin
                if (w_emit && (r_idx == '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ochar <= w_char;
            r_olast <= (r_state == S_DIG) && (r_idx == '0);
        end
        case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_val  <= i_item.mag;
                r_len  <= 4'd0;
            end
            S_MUL: begin
                r_q <= w_prod[63:pita_pkg::RECIP_SHIFT];
            end
            S_DIV, S_HEX: begin
                if (r_state == S_DIV) begin
                    r_buf[r_len[pita_pkg::BUF_AW-1:0]] <= pita_pkg::nibble_char(w_rem[3:0], 1'b0);
                    r_val <= 32'(r_q);
                end else begin
                    r_buf[r_len[pita_pkg::BUF_AW-1:0]] <= pita_pkg::nibble_char(r_val[3:0],
                                                                             r_item.upper);
                    r_val <= {4'd0, r_val[31:4]};
                end
                r_len  <= w_nlen;
                r_idx  <= r_len[pita_pkg::BUF_AW-1:0];
                r_pads <= w_pads_new;
            end
            S_PAD: begin
                if (w_emit) begin
                    r_pads <= r_pads - 6'd1;
                end
            end
            S_DIG: begin
                if (w_emit && (r_idx != '0)) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_ascii_char = r_ochar;
    assign o_last       = r_olast;

endmodule

// File: rtl/padded_integer_to_ascii_core.sv
// ----------------------------------------------------------------------------
// padded_integer_to_ascii_core: printf-style integer formatter
// Formats one 32-bit value as signed/unsigned decimal, lower/upper hex or a
// "0x" pointer, left padded to a field width, one ASCII character per output
// transaction, with the final character flagged.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_mode, i_value, i_field_width,
//                                            i_pad_zero
//   output   out        o_valid / i_ready    o_ascii_char, o_last
//
// Sequence: the engine picks up an item, then works through each decimal digit
// with a reciprocal multiply and then a remainder step, or through each hex
// digit with a nibble step, then emits each character in turn.
// Reset: synchronous, active low; clears the queue, engine state and output
// valid. No clearing pass.
// Stalls: the item queue lets the input side keep accepting, until it fills,
// while the engine works or the output is stalled; the output register holds
// its character until taken.
// ----------------------------------------------------------------------------
module padded_integer_to_ascii_core #(
    parameter int FIFO_DEPTH = pita_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_field_width,
    input  logic        i_pad_zero,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_ascii_char,
    output logic        o_last
);

    pita_pkg::t_item w_push_item, w_head_item;
    logic            w_push, w_full, w_head_valid, w_pop;

    // classify the incoming transaction and push it into the queue
    pita_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_field_width (i_field_width),
        .i_pad_zero    (i_pad_zero),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    // hold classified items until the engine is free
    pita_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .i_pop   (w_pop),
        .o_data  (w_head_item)
    );

    // convert and stream characters, one item at a time
    pita_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_head_valid),
        .i_item       (w_head_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

endmodule

// File: rtl/pita_checker.sv
// ----------------------------------------------------------------------------
// pita_checker: port-level checks of the formatter
// Watches the output channel for held transactions and legal characters.
// ----------------------------------------------------------------------------
module pita_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_ascii_char,
    input logic       o_last
);

    logic w_is_digit, w_is_legal;

    assign w_is_digit = ((o_ascii_char >= pita_pkg::CH_ZERO) && (o_ascii_char <= pita_pkg::CH_NINE))
                     || ((o_ascii_char >= pita_pkg::CH_UA) && (o_ascii_char <= pita_pkg::CH_UF))
                     || ((o_ascii_char >= pita_pkg::CH_LA) && (o_ascii_char <= pita_pkg::CH_LF));
    assign w_is_legal = w_is_digit || (o_ascii_char == pita_pkg::CH_SPACE)
                     || (o_ascii_char == pita_pkg::CH_MINUS) || (o_ascii_char == pita_pkg::CH_X);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ascii_char) && $stable(o_last))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> w_is_digit)
        else $error("final character is not a digit");

    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_is_legal)
        else $error("illegal character emitted");

endmodule

bind padded_integer_to_ascii_core pita_checker u_pita_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_ascii_char (o_ascii_char),
    .o_last       (o_last)
);

// File: dv/padded_integer_to_ascii_core_test.sv
// ----------------------------------------------------------------------------
// padded_integer_to_ascii_core_test: self-checking bench for the formatter
// Drives formatted-integer requests into the core and checks every emitted
// character, and its last flag, against a bench-side formatter. Covers all
// modes, the width and pad corner cases, random operands, idling on both
// channels, a long output hold-off that backs up the input, and full rate.
// ----------------------------------------------------------------------------
module padded_integer_to_ascii_core_test;

    // Mode codes past pointer; the core formats these as unsigned decimal.
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    // Worst case: a 64-character field, mostly stalled output, 193 requests.
    localparam int CLK_PERIOD   = 12;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RUN_LIMIT    = CLK_PERIOD * 500000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_exp_char;

    // ------------------------------------------------------------------------
    // Scoreboard: formats each accepted request and checks emitted characters
    // ------------------------------------------------------------------------
    class fmt_scoreboard;
        t_exp_char expected_chars[$];
        int        errors;
        int        values_seen;
        int        chars_seen;
        int        longest_field;

        function new();
            errors        = 0;
            values_seen   = 0;
            chars_seen    = 0;
            longest_field = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Build the expected text of one request, most significant first.
        function void note_item(input logic [2:0] mode, input logic [31:0] value,
                                input logic [5:0] fw, input logic pz);
            int          w;
            int          len;
            int          i;
            logic [31:0] mag;
            logic [3:0]  nib;
            logic        neg;
            logic        hex;
            logic        upper;
            logic [7:0]  padc;
            logic [7:0]  digits[$];
            logic [7:0]  text[$];
            t_exp_char   ent;

            w     = (fw > pita_pkg::MAX_WIDTH) ? int'(pita_pkg::MAX_WIDTH) : int'(fw);
            padc  = pz ? pita_pkg::CH_ZERO : pita_pkg::CH_SPACE;
            neg   = 1'b0;
            hex   = 1'b0;
            upper = 1'b0;
            mag   = value;

            case (mode)
                pita_pkg::MODE_SDEC: begin
                    if (value[31]) begin
                        neg = 1'b1;
                        mag = 32'd0 - value;
                    end
                end
                pita_pkg::MODE_HEXL: hex = 1'b1;
                pita_pkg::MODE_HEXU: begin
                    hex   = 1'b1;
                    upper = 1'b1;
                end
                pita_pkg::MODE_PTR: begin
                    hex  = 1'b1;
                    padc = pita_pkg::CH_ZERO;
                    if (w == 0) w = int'(pita_pkg::PTR_WIDTH);
                    text.push_back(pita_pkg::CH_ZERO);
                    text.push_back(pita_pkg::CH_X);
                end
                default: ;
            endcase

            do begin
                if (hex) begin
                    nib = mag[3:0];
                    mag = mag >> 4;
                end else begin
                    nib = 4'(mag % 32'd10);
                    mag = mag / 32'd10;
                end
                if (nib < 4'd10)
                    digits.push_front(pita_pkg::CH_ZERO + {4'b0, nib});
                else
                    digits.push_front((upper ? pita_pkg::CH_UA : pita_pkg::CH_LA)
                                      + {4'b0, nib} - 8'd10);
            end while (mag != 32'd0);
            len = digits.size();

            if (neg && pz) begin
                text.push_back(pita_pkg::CH_MINUS);
                if (w > 0) w--;
                for (i = len; i < w; i++) text.push_back(pita_pkg::CH_ZERO);
            end else if (neg) begin
                for (i = len + 1; i < w; i++) text.push_back(pita_pkg::CH_SPACE);
                text.push_back(pita_pkg::CH_MINUS);
            end else begin
                for (i = len; i < w; i++) text.push_back(padc);
            end
            foreach (digits[k]) text.push_back(digits[k]);

            foreach (text[k]) begin
                ent.ch   = text[k];
                ent.last = (k == text.size() - 1);
                expected_chars.push_back(ent);
            end
            values_seen++;
            if (text.size() > longest_field) longest_field = text.size();
        endfunction

        task check_char(input logic [7:0] ch, input logic last);
            t_exp_char ent;
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
            end else begin
                ent = expected_chars.pop_front();
                if (ch !== ent.ch)
                    report($sformatf("char 0x%02h, expected 0x%02h", ch, ent.ch));
                if (last !== ent.last)
                    report($sformatf("last %0b, expected %0b (char 0x%02h)",
                                     last, ent.last, ent.ch));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_mode;
    logic [31:0] i_value;
    logic [5:0]  i_field_width;
    logic        i_pad_zero;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_ascii_char;
    logic        o_last;

    padded_integer_to_ascii_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_field_width (i_field_width),
        .i_pad_zero    (i_pad_zero),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ascii_char  (o_ascii_char),
        .o_last        (o_last)
    );

    fmt_scoreboard sb = new();

    // Idle rates in percent, and the remaining cycles of an output hold-off.
    int send_idle;
    int recv_idle;
    int ready_hold;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs or loses a transaction.
    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample at the edge, before any of this edge's updates land
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_item(i_mode, i_value, i_field_width, i_pad_zero);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_char(o_ascii_char, o_last);
    end

    // Output side: hold ready low while a hold-off runs, else idle at random.
    // Exactly one nonblocking write of i_ready per edge.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    // Offer one request and return at the edge where the transaction happens.
    // Drop valid only when a gap is taken, so back-to-back requests keep it
    // high with a single assignment per edge.
    task automatic send_item(input logic [2:0] m, input logic [31:0] v,
                             input logic [5:0] fw, input logic pz);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid       <= 1'b1;
        i_mode        <= m;
        i_value       <= v;
        i_field_width <= fw;
        i_pad_zero    <= pz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected character has come out.
    // Step to the next edge first so the last accepted request is in the scoreboard.
    task automatic drain_output();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 99);
            2:       return 32'h8000_0000 + $urandom_range(0, 3);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 99);
            4:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    // Keep most fields short; only a few run long, some up to the saturated width or past it.
    function automatic logic [5:0] pick_width();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)  return 6'($urandom_range(0, 12));
        if (r < 9)  return 6'($urandom_range(13, 40));
        return 6'($urandom_range(41, 63));
    endfunction

    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 9) < 9) return 3'($urandom_range(0, 4));
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_item(pick_mode(), pick_value(), pick_width(),
                                 1'($urandom_range(0, 1)));
    endtask

    // Corner cases: zero, most negative value, both pad styles on negatives,
    // saturated width, digits wider than the field, pointer default width,
    // the 64-character pointer field, and the reserved mode codes.
    task automatic send_directed();
        send_item(pita_pkg::MODE_SDEC, 32'd0,          6'd0,  1'b0);
        send_item(pita_pkg::MODE_SDEC, 32'h8000_0000,  6'd0,  1'b0);
        send_item(pita_pkg::MODE_SDEC, 32'h8000_0000,  6'd15, 1'b1);
        send_item(pita_pkg::MODE_SDEC, -32'sd42,       6'd8,  1'b0);
        send_item(pita_pkg::MODE_SDEC, -32'sd42,       6'd8,  1'b1);
        send_item(pita_pkg::MODE_SDEC, 32'h7FFF_FFFF,  6'd63, 1'b0);
        send_item(pita_pkg::MODE_SDEC, 32'hFFFF_FFFF,  6'd1,  1'b1);
        send_item(pita_pkg::MODE_SDEC, 32'hFFFF_FFFF,  6'd63, 1'b1);
        send_item(pita_pkg::MODE_SDEC, 32'h8000_0000,  6'd63, 1'b0);
        send_item(pita_pkg::MODE_UDEC, 32'hFFFF_FFFF,  6'd0,  1'b1);
        send_item(pita_pkg::MODE_UDEC, 32'd12345,      6'd63, 1'b1);
        send_item(pita_pkg::MODE_UDEC, 32'd0,          6'd62, 1'b0);
        send_item(pita_pkg::MODE_HEXL, 32'hDEAD_BEEF,  6'd10, 1'b0);
        send_item(pita_pkg::MODE_HEXU, 32'hDEAD_BEEF,  6'd10, 1'b1);
        send_item(pita_pkg::MODE_HEXL, 32'd0,          6'd0,  1'b1);
        send_item(pita_pkg::MODE_HEXU, 32'hFFFF_FFFF,  6'd3,  1'b0);
        send_item(pita_pkg::MODE_PTR,  32'h0000_1234,  6'd0,  1'b0);
        send_item(pita_pkg::MODE_PTR,  32'hFFFF_FFFF,  6'd62, 1'b0);
        send_item(pita_pkg::MODE_PTR,  32'd0,          6'd63, 1'b1);
        send_item(pita_pkg::MODE_PTR,  32'h0000_0ABC,  6'd4,  1'b0);
        send_item(MODE_RSVD5,          32'hFFFF_FFFF,  6'd12, 1'b0);
        send_item(MODE_RSVD6,          32'h8000_0000,  6'd12, 1'b1);
        send_item(MODE_RSVD7,          32'd7,          6'd2,  1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        send_idle     = 6;
        recv_idle     = 60;
        ready_hold    = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_ready       <= 1'b0;
        i_mode        <= pita_pkg::MODE_SDEC;
        i_value       <= 32'd0;
        i_field_width <= 6'd0;
        i_pad_zero    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 1: sender mostly busy, receiver stalling often.
        send_directed();
        send_random(55);
        drain_output();

        // Phase 2: sender gappy, receiver mostly ready.
        send_idle = 60;
        recv_idle = 6;
        send_random(55);
        drain_output();

        // Phase 3: no idling; first hold the output off so the input backs up.
        send_idle  = 0;
        recv_idle  = 0;
        ready_hold = HOLD_CYCLES;
        send_random(20);
        send_random(40);
        drain_output();

        $display("Formatted %0d values into %0d characters (longest field %0d): all modes",
                 sb.values_seen, sb.chars_seen, sb.longest_field);
        $display("incl. reserved codes, widths 0..63, both pads, idling both ways, long hold-off");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
